>>> design/lfr_pkg.sv
// ----------------------------------------------------------------------------
// lfr_pkg
// Types and constants of the frame store and refresh serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfr_pkg;

  localparam int COLUMNS    = 84;
  localparam int BANK_ROWS  = 6;
  localparam int STORE_SIZE = COLUMNS * BANK_ROWS;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int PHASE_W    = $clog2(COLUMNS + 2);

  localparam logic [7:0] ROW_CMD = 8'h40;
  localparam logic [7:0] COL_CMD = 8'h80;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_PULL  = 2'd2,
    CMD_MARK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PIX_CLR = 2'd0,
    PIX_SET = 2'd1,
    PIX_TGL = 2'd2
  } pmode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_CLEAR,
    ST_EMIT
  } state_t;

endpackage

>>> design/lfr_if.sv
// ----------------------------------------------------------------------------
// lfr channel interfaces
// Valid/ready channels for commands, panel bytes and the offset register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [6:0] x_column;
  logic [5:0] y_line;
  logic [1:0] pixel_mode;
  logic [2:0] first_row;
  logic [2:0] final_row;

  modport source (output valid, command, x_column, y_line, pixel_mode, first_row,
                  final_row, input ready);
  modport sink (input valid, command, x_column, y_line, pixel_mode, first_row,
                final_row, output ready);
endinterface

interface lfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       is_data;
  logic       frame_end;

  modport source (output valid, byte_value, is_data, frame_end, input ready);
  modport sink (input valid, byte_value, is_data, frame_end, output ready);
endinterface

interface lfr_cfg_if;
  logic valid;
  logic ready;
  logic row_address_offset;

  modport source (output valid, row_address_offset, input ready);
  modport sink (input valid, row_address_offset, output ready);
endinterface

>>> design/lcd_framebuffer_refresh_core.sv
// ----------------------------------------------------------------------------
// lcd_framebuffer_refresh_core
// Bank-organized frame store with pixel, clear and mark commands, serialized
// into panel command and data bytes, at most one beat per pull.
// A pull's byte goes through the emit or memory read register, then the
// output register, which holds while out_ready is low. Commands are taken
// in idle only; pixel writes read-modify-write the single memory port.
// Reset: synchronous; a pass then zeroes all 504 store bytes with in_ready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_framebuffer_refresh_core
  import lfr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  lfr_in_if.sink       in_ch,
  lfr_out_if.source    out_ch,
  lfr_cfg_if.sink      cfg_ch
);

  state_t state_r, state_nxt;

  logic [7:0]        mem [STORE_SIZE];
  logic [7:0]        rd_data_r;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic [7:0]        mem_wdata;

  logic              offset_r;
  logic              dirty_r;
  logic              busy_r;
  logic [2:0]        row_r;
  logic [PHASE_W-1:0] phase_r;
  logic [ADDR_W-1:0] ref_addr_r;

  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_end_r;

  logic [ADDR_W-1:0] pix_addr_r;
  logic [2:0]        pix_bit_r;
  pmode_t            pix_mode_r;

  logic [7:0]        emit_byte_r;
  logic              emit_mem_r;
  logic              emit_end_r;
  logic              emit_data_r;

  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_is_data_r;
  logic              out_frame_end_r;

  logic              in_ready;
  logic              out_load;
  logic              accept;
  cmd_t              cmd;
  logic              pull_go;
  logic [2:0]        eff_row;
  logic [PHASE_W-1:0] eff_phase;
  logic [2:0]        last_clamped;
  logic              clr_any;
  logic              pix_ok;
  logic [7:0]        pix_mask;
  logic [7:0]        pix_new;

  assign accept  = in_ch.valid && in_ready;
  assign cmd     = cmd_t'(in_ch.command);
  assign pull_go = accept && (cmd == CMD_PULL) && (busy_r || dirty_r);
  assign eff_row   = busy_r ? row_r : 3'd0;
  assign eff_phase = busy_r ? phase_r : '0;

  assign last_clamped = (in_ch.final_row > 3'(BANK_ROWS - 1)) ? 3'(BANK_ROWS - 1)
                                                               : in_ch.final_row;
  assign clr_any = (in_ch.first_row <= last_clamped);
  assign pix_ok  = ({1'b0, in_ch.x_column} < 8'(COLUMNS)) &&
                   ({1'b0, in_ch.y_line} < 7'(BANK_ROWS * 8)) &&
                   (in_ch.pixel_mode != 2'd3);

  assign pix_mask = 8'd1 << pix_bit_r;
  always_comb begin
    unique case (pix_mode_r)
      PIX_CLR: pix_new = rd_data_r & ~pix_mask;
      PIX_SET: pix_new = rd_data_r | pix_mask;
      PIX_TGL: pix_new = rd_data_r ^ pix_mask;
      default: pix_new = rd_data_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (clr_addr_r == clr_end_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_PIXEL: if (pix_ok) state_nxt = ST_PIX_RD;
            CMD_CLEAR: if (clr_any) state_nxt = ST_CLEAR;
            CMD_PULL:  if (pull_go) state_nxt = ST_EMIT;
            CMD_MARK:  state_nxt = ST_IDLE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD: state_nxt = ST_PIX_WR;
      ST_PIX_WR: state_nxt = ST_IDLE;
      ST_CLEAR: begin
        if (clr_addr_r == clr_end_r) state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    in_ready  = 1'b0;
    mem_addr  = ref_addr_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = 8'd0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        mem_addr = clr_addr_r;
        mem_we   = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        mem_re   = pull_go && (eff_phase > PHASE_W'(1));
      end
      ST_PIX_RD: begin
        mem_addr = pix_addr_r;
        mem_re   = 1'b1;
      end
      ST_PIX_WR: begin
        mem_addr  = pix_addr_r;
        mem_we    = 1'b1;
        mem_wdata = pix_new;
      end
      ST_EMIT: out_load = !out_valid_r || out_ch.ready;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      offset_r   <= 1'b1;
      dirty_r    <= 1'b0;
      busy_r     <= 1'b0;
      row_r      <= 3'd0;
      phase_r    <= '0;
      ref_addr_r <= '0;
      clr_addr_r <= '0;
      clr_end_r  <= ADDR_W'(STORE_SIZE - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) offset_r <= cfg_ch.row_address_offset;

      if ((state_r == ST_INIT || state_r == ST_CLEAR) && clr_addr_r != clr_end_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end

      if (accept && (cmd == CMD_CLEAR || cmd == CMD_MARK)) begin
        dirty_r <= 1'b1;
      end
      if (accept && cmd == CMD_CLEAR && clr_any) begin
        clr_addr_r <= ADDR_W'(in_ch.first_row) * ADDR_W'(COLUMNS);
        clr_end_r  <= ADDR_W'(last_clamped) * ADDR_W'(COLUMNS) + ADDR_W'(COLUMNS - 1);
      end

      if (pull_go) begin
        busy_r <= 1'b1;
        row_r  <= eff_row;
        if (!busy_r) begin
          dirty_r    <= 1'b0;
          ref_addr_r <= '0;
        end
        if (eff_phase == '0) begin
          phase_r <= PHASE_W'(1);
        end else if (eff_phase == PHASE_W'(1)) begin
          phase_r <= PHASE_W'(2);
        end else if (eff_phase == PHASE_W'(COLUMNS + 1)) begin
          phase_r <= '0;
          if (eff_row == 3'(BANK_ROWS - 1)) begin
            busy_r     <= 1'b0;
            row_r      <= 3'd0;
            ref_addr_r <= '0;
          end else begin
            row_r      <= eff_row + 3'd1;
            ref_addr_r <= ref_addr_r + ADDR_W'(1);
          end
        end else begin
          phase_r    <= eff_phase + PHASE_W'(1);
          ref_addr_r <= ref_addr_r + ADDR_W'(1);
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_PIXEL) begin
      pix_addr_r <= ADDR_W'(in_ch.y_line[5:3]) * ADDR_W'(COLUMNS) +
                    ADDR_W'(in_ch.x_column);
      pix_bit_r  <= in_ch.y_line[2:0];
      pix_mode_r <= pmode_t'(in_ch.pixel_mode);
    end
    if (pull_go) begin
      emit_mem_r  <= (eff_phase > PHASE_W'(1));
      emit_data_r <= (eff_phase > PHASE_W'(1));
      emit_end_r  <= (eff_phase == PHASE_W'(COLUMNS + 1)) &&
                     (eff_row == 3'(BANK_ROWS - 1));
      emit_byte_r <= (eff_phase == '0) ? (ROW_CMD | (8'(eff_row) + 8'(offset_r)))
                                       : COL_CMD;
    end
    if (out_load) begin
      out_byte_r      <= emit_mem_r ? rd_data_r : emit_byte_r;
      out_is_data_r   <= emit_data_r;
      out_frame_end_r <= emit_end_r;
    end
  end

  assign in_ch.ready       = in_ready;
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.byte_value = out_byte_r;
  assign out_ch.is_data    = out_is_data_r;
  assign out_ch.frame_end  = out_frame_end_r;

`ifndef NO_ASSERTIONS
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (row_r < 3'(BANK_ROWS - 1)) || (row_r == 3'(BANK_ROWS - 1)))
    else $error("refresh row out of range");

  a_addr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && phase_r > PHASE_W'(1)) |->
      ref_addr_r == ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(phase_r) - ADDR_W'(2))
    else $error("refresh address out of step with row and phase");

  a_end_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_end_r) |-> out_is_data_r)
    else $error("frame end on a command byte");

  a_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> clr_addr_r <= clr_end_r)
    else $error("clear sweep passed its end");

  a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (ref_addr_r == '0) && (row_r == 3'd0))
    else $error("refresh pointer not rewound at frame end");
`endif

endmodule
